// ===== rtl/core/sea_pkg.sv =====
`timescale 1ns / 1ps
package sea_pkg;

  // Default table depth
  localparam int ENV_DEPTH_DEF = 256;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 8;
  localparam int AMP_W  = 24;
  localparam int FREQ_W = 24;
  localparam int STS_W  = 2;
  localparam int NSZ_W  = 9;
  localparam int MF_W   = 16;
  localparam int FAC_W  = 17;
  localparam int CFG_W  = 17;
  localparam int CIDX_W = 2;

  // Quotient bits of the bin position: integer bin plus 16 fraction bits
  localparam int Q_W    = 25;
  localparam int FRAC_W = 16;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ENV_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_FREQ = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FACTOR   = 2'd2;

  // Reset values
  localparam logic [NSZ_W-1:0] ENV_SIZE_RST = 9'd256;
  localparam logic [MF_W-1:0]  MAX_FREQ_RST = 16'd22050;
  localparam logic [FAC_W-1:0] FACTOR_RST   = 17'd0;

  // 1.0 in Q1.16
  localparam logic [FAC_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_INTERP = 2'd1,
    CMD_APPLY  = 2'd2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_CLAMP = 2'd2,
    STS_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_BIN,
    RD_BIN1,
    RD_LAST
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_AMP,
    RES_ZERO,
    RES_MEM,
    RES_BLEND
  } res_src_e;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     div_init;
    logic     div_step;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     e0_cap;
    logic     setup;
    logic     setup_apply;
    logic     blend;
    logic     res_load;
    res_src_e res_src;
    status_e  res_status;
    logic     wr_en;
    logic     wr_blend;
  } sea_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             idx_ok;
    logic             out_of_range;
    logic             last_bin;
    logic             out_free;
  } sea_sts_t;

endpackage

// ===== rtl/core/sea_datapath.sv =====
`timescale 1ns / 1ps
module sea_datapath import sea_pkg::*; #(
  parameter int ENV_DEPTH = ENV_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [CMD_W-1:0]  in_cmd_i,
  input  logic [IDX_W-1:0]  in_idx_i,
  input  logic [AMP_W-1:0]  in_amp_i,
  input  logic [FREQ_W-1:0] in_freq_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [AMP_W-1:0]  out_value_o,
  output logic [STS_W-1:0]  out_status_o,
  output logic              out_last_o,
  input  sea_cmd_t          cmd_i,
  output sea_sts_t          sts_o
);

  localparam int AW = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1;
  localparam int N_CAP = (ENV_DEPTH > 511) ? 511 : ENV_DEPTH;
  localparam logic [NSZ_W-1:0] N_CAP_V = NSZ_W'(N_CAP);
  localparam int PW = FREQ_W + NSZ_W;
  localparam int BW = AMP_W + 1 + FAC_W + 1;

  // Configuration
  logic [NSZ_W-1:0] env_size_q;
  logic [MF_W-1:0]  max_freq_q;
  logic [FAC_W-1:0] factor_q;

  // Captured item
  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [AMP_W-1:0]  amp_q;
  logic [FREQ_W-1:0] freq_q;
  logic              last_q;

  // Divider
  logic [MF_W-1:0] rem_q;
  logic [Q_W-1:0]  dvd_q;

  // Table
  logic [AMP_W-1:0] mem_q [ENV_DEPTH];
  logic [AMP_W-1:0] rdata_q;
  logic [AMP_W-1:0] e0_q;

  // Blend unit
  logic [AMP_W-1:0]       base_q;
  logic [AMP_W-1:0]       other_q;
  logic [FAC_W-1:0]       weight_q;
  logic signed [BW-1:0]   bprod_q;

  // Result register
  logic              out_valid_q;
  logic [AMP_W-1:0]  res_value_q;
  logic [STS_W-1:0]  res_status_q;
  logic              res_last_q;

  logic [NSZ_W-1:0]   n_eff;
  logic [NSZ_W-1:0]   n_m1;
  logic [PW-1:0]      fn_prod;
  logic [MF_W:0]      trial;
  logic               q_bit;
  logic [NSZ_W-1:0]   bin;
  logic [FRAC_W-1:0]  frac;
  logic [15:0]        addr_wide;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AMP_W-1:0]   wr_data;
  logic [AMP_W-1:0]   a1;
  logic [AMP_W-1:0]   a2;
  logic [FAC_W-1:0]   fac_lim;
  logic signed [AMP_W:0] bdiff;
  logic [BW-1:0]      rnd_sum;
  logic [AMP_W-1:0]   blend_val;
  logic [AMP_W-1:0]   res_value_d;

  assign n_eff   = (env_size_q > N_CAP_V) ? N_CAP_V : env_size_q;
  assign n_m1    = n_eff - NSZ_W'(1);
  assign fn_prod = PW'(freq_q) * PW'(n_eff);
  assign bin     = dvd_q[Q_W-1:FRAC_W];
  assign frac    = dvd_q[FRAC_W-1:0];

  // Restoring division step: remainder stays below max_freq
  assign trial = {rem_q, dvd_q[Q_W-1]};
  assign q_bit = (trial >= {1'b0, max_freq_q});

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  addr_wide = {8'd0, idx_q};
      RD_BIN:  addr_wide = {7'd0, bin};
      RD_BIN1: addr_wide = {7'd0, bin} + 16'd1;
      RD_LAST: addr_wide = {7'd0, n_m1};
      default: addr_wide = '0;
    endcase
  end

  assign rd_addr = addr_wide[AW-1:0];
  assign wr_addr = AW'({8'd0, idx_q});

  // Blend operands: a non-positive value takes the other one
  always_comb begin
    a1 = amp_q;
    a2 = rdata_q;
    if (amp_q[AMP_W-1] || (amp_q == '0)) begin
      a1 = rdata_q;
    end
    if (rdata_q[AMP_W-1] || (rdata_q == '0)) begin
      a2 = a1;
    end
  end

  assign fac_lim = (factor_q > ONE_Q16) ? ONE_Q16 : factor_q;

  assign bdiff     = $signed({other_q[AMP_W-1], other_q}) - $signed({base_q[AMP_W-1], base_q});
  assign rnd_sum   = bprod_q + BW'(32768);
  assign blend_val = base_q + rnd_sum[AMP_W+FRAC_W-1:FRAC_W];
  assign wr_data   = cmd_i.wr_blend ? blend_val : amp_q;

  always_comb begin
    unique case (cmd_i.res_src)
      RES_AMP:   res_value_d = amp_q;
      RES_ZERO:  res_value_d = '0;
      RES_MEM:   res_value_d = rdata_q;
      RES_BLEND: res_value_d = blend_val;
      default:   res_value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_size_q <= ENV_SIZE_RST;
      max_freq_q <= MAX_FREQ_RST;
      factor_q   <= FACTOR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ENV_SIZE) begin
        env_size_q <= cfg_data_i[NSZ_W-1:0];
      end
      if (cfg_idx_i == CFG_MAX_FREQ) begin
        max_freq_q <= cfg_data_i[MF_W-1:0];
      end
      if (cfg_idx_i == CFG_FACTOR) begin
        factor_q <= cfg_data_i[FAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= in_cmd_i;
      idx_q  <= in_idx_i;
      amp_q  <= in_amp_i;
      freq_q <= in_freq_i;
      last_q <= in_last_i;
    end
    if (cmd_i.div_init) begin
      rem_q <= fn_prod[PW-1:PW-MF_W];
      dvd_q <= {fn_prod[PW-MF_W-1:0], 8'd0};
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? MF_W'(trial - {1'b0, max_freq_q}) : trial[MF_W-1:0];
      dvd_q <= {dvd_q[Q_W-2:0], q_bit};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.e0_cap) begin
      e0_q <= rdata_q;
    end
    if (cmd_i.setup) begin
      if (cmd_i.setup_apply) begin
        base_q   <= e0_q;
        other_q  <= rdata_q;
        weight_q <= {1'b0, frac};
      end else begin
        base_q   <= a1;
        other_q  <= a2;
        weight_q <= fac_lim;
      end
    end
    if (cmd_i.blend) begin
      bprod_q <= BW'(bdiff * $signed({1'b0, weight_q}));
    end
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.res_load) begin
      res_value_q  <= res_value_d;
      res_status_q <= cmd_i.res_status;
      res_last_q   <= last_q;
    end
  end

  assign sts_o.cmd          = cmd_q;
  assign sts_o.idx_ok       = ({1'b0, idx_q} < n_eff);
  assign sts_o.out_of_range = (n_eff == '0) || (freq_q == '0) || (freq_q > {max_freq_q, 8'd0});
  assign sts_o.last_bin     = (bin >= n_m1);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = res_value_q;
  assign out_status_o = res_status_q;
  assign out_last_o   = res_last_q;

endmodule

// ===== rtl/core/sea_ctrl.sv =====
`timescale 1ns / 1ps
module sea_ctrl import sea_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sea_sts_t sts_i,
  output sea_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_POS,
    S_RD1,
    S_SETUP,
    S_BLEND,
    S_DONE
  } state_e;

  localparam logic [4:0] DIV_LAST = 5'(Q_W - 1);

  state_e   state_q;
  logic [4:0] cnt_q;
  res_src_e fin_src_q;
  status_e  fin_sts_q;
  logic     fin_wr_q;
  logic     fin_blend_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_IDX;
    cmd_o.res_src    = fin_src_q;
    cmd_o.res_status = fin_sts_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      S_DECODE: begin
        if ((sts_i.cmd == CMD_INTERP) && sts_i.idx_ok) begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.div_init = 1'b1;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_POS: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = sts_i.last_bin ? RD_LAST : RD_BIN;
      end
      S_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_BIN1;
        cmd_o.e0_cap = 1'b1;
      end
      S_SETUP: begin
        cmd_o.setup       = 1'b1;
        cmd_o.setup_apply = (sts_i.cmd == CMD_APPLY);
      end
      S_BLEND: begin
        cmd_o.blend = 1'b1;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.wr_en    = fin_wr_q;
          cmd_o.wr_blend = fin_blend_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      fin_src_q   <= RES_ZERO;
      fin_sts_q   <= STS_OK;
      fin_wr_q    <= 1'b0;
      fin_blend_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          fin_src_q   <= RES_ZERO;
          fin_sts_q   <= STS_BAD;
          fin_wr_q    <= 1'b0;
          fin_blend_q <= 1'b0;
          state_q     <= S_DONE;
          unique case (sts_i.cmd)
            CMD_LOAD: begin
              if (sts_i.idx_ok) begin
                fin_src_q <= RES_AMP;
                fin_sts_q <= STS_OK;
                fin_wr_q  <= 1'b1;
              end
            end
            CMD_INTERP: begin
              if (sts_i.idx_ok) begin
                fin_src_q   <= RES_BLEND;
                fin_sts_q   <= STS_OK;
                fin_wr_q    <= 1'b1;
                fin_blend_q <= 1'b1;
                state_q     <= S_SETUP;
              end
            end
            CMD_APPLY: begin
              if (sts_i.out_of_range) begin
                fin_sts_q <= STS_RANGE;
              end else begin
                state_q <= S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
        S_MUL: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == DIV_LAST) begin
            state_q <= S_POS;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_POS: begin
          if (sts_i.last_bin) begin
            fin_src_q <= RES_MEM;
            fin_sts_q <= STS_CLAMP;
            state_q   <= S_DONE;
          end else begin
            fin_src_q <= RES_BLEND;
            fin_sts_q <= STS_OK;
            state_q   <= S_RD1;
          end
        end
        S_RD1: begin
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          state_q <= S_BLEND;
        end
        S_BLEND: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> sts_i.out_free)
    else $error("result loaded while output word still pending");

  a_wr_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (sts_i.idx_ok && ((sts_i.cmd == CMD_LOAD) || (sts_i.cmd == CMD_INTERP))))
    else $error("table write without a valid load or interpolate");

  a_setup_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.setup |-> $past(cmd_o.rd_en))
    else $error("blend setup without a preceding table read");

  a_e0_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.e0_cap |-> $past(cmd_o.rd_en && (cmd_o.rd_sel == RD_BIN)))
    else $error("lower bin captured without a bin read");
`endif

endmodule

// ===== rtl/core/spectral_envelope_apply_interp.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata index,amp,freq; tuser cmd; tlast
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata value; tuser status; tlast
// cfg       in         cfg_we_i                       cfg_idx_i, cfg_data_i
//
// One word at a time. Load, bad and out-of-range words go from decode to done;
// interpolate reads its entry, sets up operands and blends; an in-range peak runs
// the restoring divider by max_freq, one quotient bit per cycle over 25 bits, then
// two reads of the single read port, operand setup and the blend multiply (a clamp
// to the last bin reads once). Reset returns control to idle and config to its
// defaults; table contents are undefined until loaded.
// A pending result sits in the output register while the next word is taken;
// that word finishes only once the output register is free or being read.
module spectral_envelope_apply_interp import sea_pkg::*; #(
  parameter int ENV_DEPTH = ENV_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,   // index[7:0], amp[31:8], freq[55:32]
  input  logic [1:0]        s_axis_tuser,   // cmd[1:0]
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // value[23:0]
  output logic [1:0]        m_axis_tuser,   // status[1:0]
  output logic              m_axis_tlast
);

  sea_cmd_t cmd;
  sea_sts_t sts;

  sea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sea_datapath #(
    .ENV_DEPTH (ENV_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_idx_i     (s_axis_tdata[7:0]),
    .in_amp_i     (s_axis_tdata[31:8]),
    .in_freq_i    (s_axis_tdata[55:32]),
    .in_last_i    (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== sim/spectral_envelope_apply_interp_tb.sv =====
`timescale 1ns / 1ps
module spectral_envelope_apply_interp_tb;
  import sea_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic signed [AMP_W-1:0] value;
    status_e                 status;
    logic                    last;
  } env_result_t;

  class envelope_scoreboard;
    logic signed [AMP_W-1:0] env_q [ENV_DEPTH_DEF];
    bit                      loaded [ENV_DEPTH_DEF];
    int unsigned             n_used;
    logic [MF_W-1:0]         span_hz;
    logic [FAC_W-1:0]        weight;
    env_result_t             expected_words [$];
    int                      errors;

    function new();
      n_used = ENV_SIZE_RST;
      span_hz = MAX_FREQ_RST;
      weight = FACTOR_RST;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_config(logic [NSZ_W-1:0] es, logic [MF_W-1:0] mf, logic [FAC_W-1:0] fac);
      n_used = (es > ENV_DEPTH_DEF) ? ENV_DEPTH_DEF : es;
      span_hz = mf;
      weight = (fac > ONE_Q16) ? ONE_Q16 : fac;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function bit in_range(logic [FREQ_W-1:0] freq);
      return n_used != 0 && freq != 0 && longint'(freq) <= (longint'(span_hz) << 8);
    endfunction

    // Q.16 bin position of a peak
    function longint bin_pos(logic [FREQ_W-1:0] freq);
      return (longint'(freq) * longint'(n_used) * 256) / longint'(span_hz);
    endfunction

    // base + (other - base) * w / 65536, halves rounded up
    function longint blend(longint base, longint other, longint w);
      return base + (((other - base) * w + 32768) >>> 16);
    endfunction

    // Entry that the word would read while still unloaded, or -1
    function int unread_entry(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                              logic [FREQ_W-1:0] freq);
      longint bin;
      if (cmd == CMD_INTERP && idx < n_used && !loaded[idx]) return int'(idx);
      if (cmd != CMD_APPLY || !in_range(freq)) return -1;
      bin = bin_pos(freq) >>> 16;
      if (bin >= longint'(n_used) - 1) return loaded[n_used - 1] ? -1 : int'(n_used - 1);
      if (!loaded[bin]) return int'(bin);
      if (!loaded[bin + 1]) return int'(bin + 1);
      return -1;
    endfunction

    function void predict_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                               logic signed [AMP_W-1:0] amp, logic [FREQ_W-1:0] freq,
                               logic last);
      env_result_t r;
      longint a1, a2, pos, bin, frac;
      r.value = '0;
      r.status = STS_OK;
      r.last = last;
      case (cmd)
        CMD_LOAD: begin
          if (idx < n_used) begin
            env_q[idx] = amp;
            loaded[idx] = 1'b1;
            r.value = amp;
          end else r.status = STS_BAD;
        end
        CMD_INTERP: begin
          if (idx < n_used) begin
            a1 = amp;
            a2 = env_q[idx];
            // a value at or below zero takes the other side
            if (a1 <= 0) a1 = a2;
            if (a2 <= 0) a2 = a1;
            r.value = AMP_W'(blend(a1, a2, longint'(weight)));
            env_q[idx] = r.value;
          end else r.status = STS_BAD;
        end
        CMD_APPLY: begin
          if (!in_range(freq)) r.status = STS_RANGE;
          else begin
            pos = bin_pos(freq);
            bin = pos >>> 16;
            frac = pos & 64'hFFFF;
            if (bin < longint'(n_used) - 1) begin
              r.value = AMP_W'(blend(env_q[bin], env_q[bin + 1], frac));
            end else begin
              r.value = env_q[n_used - 1];
              r.status = STS_CLAMP;
            end
          end
        end
        default: r.status = STS_BAD;
      endcase
      expected_words.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [AMP_W-1:0] value, status_e status, logic last);
      env_result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word value %h status %0d", value, status));
        return;
      end
      want = expected_words.pop_front();
      if (value !== want.value)
        report($sformatf("value %h, want %h", value, want.value));
      if (status !== want.status)
        report($sformatf("status %0d, want %0d", status, want.status));
      if (last !== want.last)
        report($sformatf("tlast %b, want %b", last, want.last));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata = '0;   // index[7:0], amp[31:8], freq[55:32]
  logic [1:0]          s_axis_tuser = '0;   // cmd[1:0]
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // value[23:0]
  logic [1:0]          m_axis_tuser;        // status[1:0]
  logic                m_axis_tlast;

  envelope_scoreboard sb;
  int  tx_gap = 0;
  int  tx_run = 0;
  bit  tx_busy = 1'b0;
  int  rx_run = 0;
  bit  rx_busy = 1'b0;
  bit  rx_long_hold = 1'b0;
  int  stall_cycles = 0;

  spectral_envelope_apply_interp DUT (.*);

  always #4 clk_i = ~clk_i;

  // Runs of back-to-back words mix at random with runs of random gaps
  function automatic int draw_gap(ref int run, ref bit busy);
    if (run == 0) begin
      run = $urandom_range(8, 60);
      busy = ($urandom_range(0, 3) == 0);
    end
    run--;
    return busy ? 0 : $urandom_range(0, 17);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, status_e'(m_axis_tuser), m_axis_tlast);
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : result_sink
    int hold;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_long_hold) begin
        hold = LONG_HOLD;
        rx_long_hold = 1'b0;
      end else hold = draw_gap(rx_run, rx_busy);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task program_regs(input logic [NSZ_W-1:0] es, input logic [MF_W-1:0] mf,
                    input logic [FAC_W-1:0] fac);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ENV_SIZE;
    cfg_data_i <= CFG_W'(es);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_FREQ;
    cfg_data_i <= CFG_W'(mf);
    @(posedge clk_i);
    cfg_idx_i <= CFG_FACTOR;
    cfg_data_i <= CFG_W'(fac);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(es, mf, fac);
  endtask

  // more: another word follows right away, so tvalid may stay high
  task send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                 input logic signed [AMP_W-1:0] amp, input logic [FREQ_W-1:0] freq,
                 input logic last, input bit more);
    int slot;
    // never read an entry before it has been loaded: load it instead
    slot = sb.unread_entry(cmd, idx, freq);
    if (slot >= 0) begin
      cmd = CMD_LOAD;
      idx = IDX_W'(slot);
    end
    repeat (tx_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {freq, amp, idx};
    s_axis_tuser <= cmd;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_word(cmd, idx, amp, freq, last);
    tx_gap = more ? draw_gap(tx_run, tx_busy) : 0;
    if (!more || tx_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  task random_word(input bit more);
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        idx;
    logic signed [AMP_W-1:0] amp;
    logic [FREQ_W-1:0]       freq;
    logic                    last;
    int unsigned             pick;
    longint                  top;
    pick = $urandom_range(0, 99);
    cmd = (pick < 30) ? CMD_LOAD : (pick < 58) ? CMD_INTERP : (pick < 95) ? CMD_APPLY : CMD_BAD;
    if (sb.n_used != 0 && $urandom_range(0, 3) != 0)
      idx = IDX_W'($urandom_range(0, sb.n_used - 1));
    else idx = IDX_W'($urandom);
    case ($urandom_range(0, 5))
      0: amp = AMP_W'($urandom);
      1: amp = AMP_W'($urandom_range(1, 24'h3FFFF));
      2: amp = '0;
      3: amp = AMP_W'(-int'($urandom_range(1, 4096)));
      4: amp = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: amp = {1'b0, 23'($urandom)};
    endcase
    top = longint'(sb.span_hz) << 8;
    case ($urandom_range(0, 9))
      0: freq = FREQ_W'($urandom);
      1: freq = '0;
      2: freq = FREQ_W'(top);
      3: freq = FREQ_W'(top + 1);
      4: freq = FREQ_W'(top - $urandom_range(0, top / (sb.n_used + 1)));
      default: freq = (top > 0) ? FREQ_W'($urandom_range(1, top)) : FREQ_W'($urandom);
    endcase
    last = 1'($urandom_range(0, 1));
    send_word(cmd, idx, amp, freq, last, more);
  endtask

  task run_phase(input logic [NSZ_W-1:0] es, input logic [MF_W-1:0] mf,
                 input logic [FAC_W-1:0] fac, input int count, input bit long_hold);
    program_regs(es, mf, fac);
    for (int k = 0; k < count; k++) begin
      // let the output side stall long enough to back up the input
      if (long_hold && k == 20) rx_long_hold = 1'b1;
      random_word(k != count - 1 && k != count / 2);
      if (k == count / 2) wait_drained();
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: 256 entries over 22050 Hz, no blend weight
    send_word(CMD_LOAD,   8'd0,   24'h7FFFFF, 24'd0,      1'b0, 1'b1);
    send_word(CMD_LOAD,   8'd1,   24'h800000, 24'd0,      1'b1, 1'b1);
    send_word(CMD_LOAD,   8'd255, 24'h010000, 24'd0,      1'b0, 1'b1);
    send_word(CMD_LOAD,   8'd254, 24'h000000, 24'd0,      1'b0, 1'b1);
    send_word(CMD_INTERP, 8'd0,   24'h123456, 24'd0,      1'b0, 1'b1);
    send_word(CMD_INTERP, 8'd1,   24'hFFFFFB, 24'd0,      1'b1, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd0,      1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd5644800, 1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd5644801, 1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'hFFFFFF, 1'b1, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd1,      1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd11025,  1'b0, 1'b1);
    send_word(CMD_BAD,    8'd255, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);

    // two-entry table, unit span, full weight: bad index and both ends of the table
    program_regs(9'd2, 16'd1, ONE_Q16);
    send_word(CMD_LOAD,   8'd2,   24'h000100, 24'd0,      1'b0, 1'b1);
    send_word(CMD_INTERP, 8'd255, 24'h000100, 24'd0,      1'b0, 1'b1);
    send_word(CMD_INTERP, 8'd1,   24'h400000, 24'd0,      1'b1, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd256,    1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd127,    1'b1, 1'b0);

    // size past the table depth, widest span, weight above one
    program_regs(9'd511, 16'd65535, 17'h1FFFF);
    send_word(CMD_INTERP, 8'd255, 24'h000200, 24'd0,      1'b0, 1'b1);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'hFFFF00, 1'b1, 1'b1);
    send_word(CMD_LOAD,   8'd255, 24'h0F0F0F, 24'd0,      1'b0, 1'b0);

    // empty table and zero span
    program_regs(9'd0, 16'd0, 17'd32768);
    send_word(CMD_APPLY,  8'd0,   24'd0,      24'd100,    1'b0, 1'b1);
    send_word(CMD_LOAD,   8'd0,   24'h000001, 24'd0,      1'b1, 1'b0);

    run_phase(9'd256, 16'd22050, 17'($urandom_range(0, 65536)), 190, 1'b0);
    run_phase(9'd2,   16'd1,     ONE_Q16,                       190, 1'b0);
    run_phase(9'd256, 16'd65535, 17'd32768,                     190, 1'b1);
    run_phase(9'd17,  16'd440,   17'($urandom_range(0, 65536)), 190, 1'b0);
    run_phase(9'd64,  16'd48000, 17'd0,                         190, 1'b0);
    run_phase(9'd511, 16'd1,     17'h1FFFF,                     190, 1'b0);
    run_phase(9'd3,   16'd65535, 17'd1,                         190, 1'b0);
    run_phase(9'd200, 16'($urandom_range(1, 65535)), 17'($urandom_range(0, 65536)), 190, 1'b0);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
